### hw/rtl/tsd_pkg.sv
// Shared types and constants for the work-stealing task deque.
`timescale 1ns / 1ps

package tsd_pkg;

   // Width of one task handle
   localparam int HANDLE_W = 32;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_STEAL = 2'd2
   } action_type;

   // Per-cycle issue information from the controller to the response stage
   typedef struct packed {
      logic valid;
      logic success;
      logic from_mem;
      logic last;
   } issue_type;

endpackage

### hw/rtl/tsd_ring_mem.sv
// Ring storage for task handles: one write port, one registered read port.
`timescale 1ns / 1ps

module tsd_ring_mem
   import tsd_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [HANDLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [HANDLE_W-1:0] rd_data
);

   logic [HANDLE_W-1:0] mem_ff [DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;

   // Write the pushed handle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tsd_ctrl.sv
// Pointer, count and steal sequencer control for the task deque.
`timescale 1ns / 1ps

module tsd_ctrl
   import tsd_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int CHUNK    = 4,
   parameter int SLOT_W   = 8,
   parameter int COUNT_W  = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_action,
   input  logic [HANDLE_W-1:0] req_task_handle,
   output logic                busy,
   output logic                wr_en,
   output logic [SLOT_W-1:0]   wr_addr,
   output logic [HANDLE_W-1:0] wr_data,
   output logic                rd_en,
   output logic [SLOT_W-1:0]   rd_addr,
   output issue_type           issue,
   output logic [COUNT_W-1:0]  issue_occ
);

   localparam int LEFT_W = $clog2(CHUNK + 1);

   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEFT_W-1:0]  left_ff, left_in;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
      return (p == SLOT_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] p);
      return (p == '0) ? SLOT_W'(CAPACITY - 1) : p - 1'b1;
   endfunction

   // Hold off new requests while a steal still has reads to issue
   assign busy = (left_ff != '0);

   // Decide the memory access and pointer update of this cycle
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = req_task_handle;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      issue     = '0;
      issue_occ = count_ff;

      if (left_ff != '0) begin
         // Continue a steal: take the next oldest handle
         rd_en          = 1'b1;
         head_in        = slot_inc(head_ff);
         count_in       = count_ff - 1'b1;
         left_in        = left_ff - 1'b1;
         issue.valid    = 1'b1;
         issue.success  = 1'b1;
         issue.from_mem = 1'b1;
         issue.last     = (left_ff == LEFT_W'(1));
         issue_occ      = count_ff - 1'b1;
      end else if (start) begin
         issue.valid = 1'b1;
         issue.last  = 1'b1;
         unique case (action_type'(req_action))
            ACT_PUSH: begin
               if (count_ff != COUNT_W'(CAPACITY)) begin
                  wr_en         = 1'b1;
                  tail_in       = slot_inc(tail_ff);
                  count_in      = count_ff + 1'b1;
                  issue.success = 1'b1;
                  issue_occ     = count_ff + 1'b1;
               end
            end
            ACT_POP: begin
               if (count_ff != '0) begin
                  rd_en          = 1'b1;
                  issue.success  = 1'b1;
                  issue.from_mem = 1'b1;
                  count_in       = count_ff - 1'b1;
                  issue_occ      = count_ff - 1'b1;
                  if (count_ff == COUNT_W'(1)) begin
                     // Single handle: take it from the head, tail already one past
                     head_in = slot_inc(head_ff);
                  end else begin
                     rd_addr = slot_dec(tail_ff);
                     tail_in = slot_dec(tail_ff);
                  end
               end
            end
            ACT_STEAL: begin
               if (count_ff != '0) begin
                  rd_en          = 1'b1;
                  head_in        = slot_inc(head_ff);
                  count_in       = count_ff - 1'b1;
                  issue.success  = 1'b1;
                  issue.from_mem = 1'b1;
                  issue_occ      = count_ff - 1'b1;
                  if (32'(count_ff) >= 32'(CHUNK)) begin
                     left_in = LEFT_W'(CHUNK - 1);
                  end else begin
                     left_in = LEFT_W'(32'(count_ff) - 32'd1);
                  end
                  issue.last = (left_in == '0);
               end
            end
            default: begin
               // Unknown action: report occupancy, change nothing
               issue.success = 1'b0;
            end
         endcase
      end
   end

   // Advance pointers, count and steal counter
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         left_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         left_ff  <= left_in;
      end
   end

endmodule

### hw/rtl/work_stealing_task_deque.sv
// Top level of the work-stealing task deque: controller, ring memory and response stage.
`timescale 1ns / 1ps

// Bounded deque of 32-bit task handles held in a single-port-read ring memory.
// A request is taken when start is high and busy is low. Push and pop may
// follow back to back; each gives one response on the cycle after it is
// taken. A steal returns min(occupancy, CHUNK) responses, oldest handle
// first, one per cycle from the memory read port, and keeps busy high until
// its last read is issued; an empty steal gives a single failed response.
// Every response is shown for exactly one cycle with rsp_valid high and
// cannot be held off. rsp_occupancy is the handle count after that response.
module work_stealing_task_deque
   import tsd_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int CHUNK    = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic [HANDLE_W-1:0]                  req_task_handle,
   output logic                                 rsp_valid,
   output logic                                 rsp_success,
   output logic [HANDLE_W-1:0]                  rsp_handle_out,
   output logic [$clog2(CAPACITY + 1)-1:0]      rsp_occupancy,
   output logic                                 rsp_last
);

   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [HANDLE_W-1:0] wr_data;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic [HANDLE_W-1:0] rd_data;
   issue_type           issue;
   logic [COUNT_W-1:0]  issue_occ;

   logic                rsp_valid_ff;
   logic                rsp_success_ff;
   logic                rsp_from_mem_ff;
   logic                rsp_last_ff;
   logic [COUNT_W-1:0]  rsp_occ_ff;

   tsd_ctrl #(
      .CAPACITY (CAPACITY),
      .CHUNK    (CHUNK),
      .SLOT_W   (SLOT_W),
      .COUNT_W  (COUNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_action      (req_action),
      .req_task_handle (req_task_handle),
      .busy            (busy),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .issue           (issue),
      .issue_occ       (issue_occ)
   );

   tsd_ring_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SLOT_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Strobe the response in the cycle after issue, aligned with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= issue.valid;
      end
   end

   // Capture the response fields
   always_ff @(posedge clock) begin
      rsp_success_ff  <= issue.success;
      rsp_from_mem_ff <= issue.from_mem;
      rsp_last_ff     <= issue.last;
      rsp_occ_ff      <= issue_occ;
   end

   // Drop the handle to zero when nothing was read
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_handle_out = rsp_from_mem_ff ? rd_data : '0;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
